/* design/binned_contact_separation_energy_defines.svh */
// Assertion macros shared by the checker of the contact separation energy block.
`ifndef BINNED_CONTACT_SEPARATION_ENERGY_DEFINES_SVH
`define BINNED_CONTACT_SEPARATION_ENERGY_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define BCSE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define BCSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/bcse_pkg.sv */
// Shared types, constants and helpers of the contact separation energy block.
package bcse_pkg;

	localparam int unsigned MAX_BEADS_DEF      = 64;
	localparam int unsigned NUM_BINS_DEF       = 64;
	localparam int unsigned MAX_SEPARATION_DEF = 1024;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned DIV_W      = 10;
	localparam int unsigned BIN_Q_W    = 11;
	localparam int unsigned SUM_W      = 48;

	typedef enum logic [1:0] {
		MODE_BEAD   = 2'd0,
		MODE_WEIGHT = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		RULE_LINEAR = 2'd0,
		RULE_DENSE  = 2'd1,
		RULE_LOOKUP = 2'd2,
		RULE_SPARE  = 2'd3
	} rule_t;

	typedef enum logic [2:0] {
		REG_BIN_RULE   = 3'd0,
		REG_LINEAR_SZ  = 3'd1,
		REG_SMALL_CNT  = 3'd2,
		REG_SMALL_SZ   = 3'd3,
		REG_BIG_SZ     = 3'd4,
		REG_SEP_START  = 3'd5,
		REG_SEP_CUTOFF = 3'd6,
		REG_DOUBLE     = 3'd7
	} cfg_reg_t;

	// A bin size of zero behaves as one.
	function automatic logic [CFG_DATA_W-1:0] nz_size(input logic [CFG_DATA_W-1:0] v);
		return (v == '0) ? CFG_DATA_W'(1) : v;
	endfunction

endpackage

/* design/bcse_div.sv */
// Restoring divider, one quotient bit per cycle, used by the linear and dense binning rules.
module bcse_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [bcse_pkg::DIV_W-1:0]          dividend,
	input  logic [bcse_pkg::CFG_DATA_W-1:0]     divisor,
	output logic                                done,
	output logic [bcse_pkg::DIV_W-1:0]          quotient
);

	localparam int unsigned CNT_W = $clog2(bcse_pkg::DIV_W + 1);

	logic [bcse_pkg::CFG_DATA_W-1:0] rem_q;
	logic [bcse_pkg::CFG_DATA_W-1:0] dvs_q;
	logic [bcse_pkg::DIV_W-1:0]      quo_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            run_q;
	logic                            done_q;
	logic [bcse_pkg::CFG_DATA_W-1:0] trial;
	logic                            fits;

	assign trial = {rem_q[bcse_pkg::CFG_DATA_W-2:0], quo_q[bcse_pkg::DIV_W-1]};
	assign fits  = (trial >= dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(bcse_pkg::DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? (trial - dvs_q) : trial;
			quo_q <= {quo_q[bcse_pkg::DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/binned_contact_separation_energy.sv */
// Top level: bead store, weight and lookup memories, pair sequencer and accumulator.
// Load words (modes 1 and 2, and the unused mode) never raise busy.
// A bead word visits its self pair, then each stored bead: a pair is divided, looked up,
// or skipped when it lies outside the window.
// Busy stays high while a bead word is worked on; done lasts one cycle.
// After reset busy stays high while both tables clear.
module binned_contact_separation_energy #(
	parameter int unsigned MAX_BEADS      = bcse_pkg::MAX_BEADS_DEF,
	parameter int unsigned NUM_BINS       = bcse_pkg::NUM_BINS_DEF,
	parameter int unsigned MAX_SEPARATION = bcse_pkg::MAX_SEPARATION_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bcse_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bcse_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          mode,
	input  logic [15:0]                         bead_index,
	input  logic [9:0]                          table_address,
	input  logic signed [31:0]                  table_value,
	input  logic                                last_bead,
	output logic                                done,
	output logic signed [bcse_pkg::SUM_W-1:0]   energy,
	output logic                                bin_overflow,
	output logic                                saturated
);

	// Widths that follow from the parameters.
	localparam int unsigned IDX_W = (MAX_BEADS > 1) ? $clog2(MAX_BEADS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_BEADS + 1);
	localparam int unsigned BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int unsigned LK_W  = $clog2(MAX_SEPARATION);
	localparam int unsigned CLR_N = (MAX_SEPARATION > NUM_BINS) ? MAX_SEPARATION : NUM_BINS;
	localparam int unsigned CLR_W = $clog2(CLR_N);
	localparam int unsigned DNS_W = 18;
	localparam logic signed [bcse_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(bcse_pkg::SUM_W-1){1'b1}}};
	localparam logic signed [bcse_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(bcse_pkg::SUM_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_FETCH, ST_DIFF, ST_SEL,
		ST_DIV, ST_LOOK, ST_BIN, ST_ADD, ST_DONE
	} state_t;

	// Configuration registers.
	logic [1:0]  rule_q;
	logic [10:0] lin_sz_q;
	logic [6:0]  small_cnt_q;
	logic [10:0] small_sz_q;
	logic [10:0] big_sz_q;
	logic [9:0]  start_q;
	logic [9:0]  cutoff_q;
	logic        dcs_q;

	// Sequencer state.
	state_t             state_q;
	logic [CLR_W-1:0]   clr_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   k_q;
	logic               self_q;
	logic [15:0]        bead_q;
	logic               last_q;
	logic [DNS_W-1:0]   dense_q;
	logic [9:0]         s_q;
	logic [6:0]         off_q;
	logic [bcse_pkg::BIN_Q_W-1:0] bin_q;
	logic signed [bcse_pkg::SUM_W-1:0] sum_q;
	logic               ovf_q;
	logic               sat_q;
	logic               done_q;
	logic signed [bcse_pkg::SUM_W-1:0] energy_q;
	logic               bin_ovf_q;
	logic               sat_out_q;

	// Memories and their registered read data.
	logic [15:0]        bead_mem [MAX_BEADS];
	logic signed [31:0] weight_mem [NUM_BINS];
	logic [BIN_W-1:0]   lookup_mem [MAX_SEPARATION];
	logic [15:0]        rd_bead_q;
	logic signed [31:0] w_q;
	logic [BIN_W-1:0]   lk_q;

	// Combinational helpers.
	logic               accept;
	logic               ld_weight;
	logic               ld_lookup;
	logic               st_we;
	state_t             adv_state;
	logic [CNT_W-1:0]   adv_k;
	logic [15:0]        partner;
	logic [15:0]        sep_d;
	logic               div_start;
	logic [bcse_pkg::DIV_W-1:0]      div_dvd;
	logic [bcse_pkg::CFG_DATA_W-1:0] div_dvs;
	logic [6:0]         sel_off;
	logic               div_done;
	logic [bcse_pkg::DIV_W-1:0]      div_quo;
	logic signed [33:0] add_v;
	logic signed [bcse_pkg::SUM_W:0] total;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign ld_weight = accept && (mode == bcse_pkg::MODE_WEIGHT) &&
		(32'(table_address) < 32'(NUM_BINS));
	assign ld_lookup = accept && (mode == bcse_pkg::MODE_LOOKUP) &&
		(32'(table_address) < 32'(MAX_SEPARATION)) && !table_value[31] &&
		(32'(table_value) < 32'(NUM_BINS));
	assign st_we = (state_q == ST_DONE) && (32'(count_q) < 32'(MAX_BEADS));

	// Where the sequencer goes once the current pair is finished.
	always_comb begin
		if (self_q) begin
			adv_k     = '0;
			adv_state = (count_q == '0) ? ST_DONE : ST_FETCH;
		end else begin
			adv_k     = k_q + CNT_W'(1);
			adv_state = (adv_k >= count_q) ? ST_DONE : ST_FETCH;
		end
	end

	// The self pair compares the bead with itself; other pairs use the fetched word.
	assign partner = self_q ? bead_q : rd_bead_q;
	assign sep_d   = (bead_q >= partner) ? (bead_q - partner) : (partner - bead_q);

	// Divider operands per binning rule. The dense rule splits at the end of the
	// dense region and adds the dense bin count to sparse quotients.
	always_comb begin
		div_dvd = s_q;
		div_dvs = bcse_pkg::nz_size(lin_sz_q);
		sel_off = '0;
		case (rule_q)
			bcse_pkg::RULE_DENSE: begin
				if (DNS_W'(s_q) > dense_q) begin
					div_dvd = s_q - dense_q[9:0];
					div_dvs = bcse_pkg::nz_size(big_sz_q);
					sel_off = small_cnt_q;
				end else begin
					div_dvs = bcse_pkg::nz_size(small_sz_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign div_start = (state_q == ST_SEL) && (rule_q != bcse_pkg::RULE_LOOKUP);

	bcse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Pairs with a nonzero shifted separation count twice, as do all other pairs
	// when double counting is on. The sum saturates at the 48-bit range.
	assign add_v = (s_q != '0 || dcs_q) ? {w_q[31], w_q, 1'b0} : {{2{w_q[31]}}, w_q};
	assign total = {sum_q[bcse_pkg::SUM_W-1], sum_q} +
		{{(bcse_pkg::SUM_W - 33){add_v[33]}}, add_v};

	// Configuration writes are taken in any state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q      <= bcse_pkg::RULE_LINEAR;
			lin_sz_q    <= 11'd1;
			small_cnt_q <= '0;
			small_sz_q  <= 11'd1;
			big_sz_q    <= 11'd1;
			start_q     <= '0;
			cutoff_q    <= 10'd1023;
			dcs_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcse_pkg::REG_BIN_RULE:   rule_q      <= cfg_data[1:0];
				bcse_pkg::REG_LINEAR_SZ:  lin_sz_q    <= cfg_data;
				bcse_pkg::REG_SMALL_CNT:  small_cnt_q <= cfg_data[6:0];
				bcse_pkg::REG_SMALL_SZ:   small_sz_q  <= cfg_data;
				bcse_pkg::REG_BIG_SZ:     big_sz_q    <= cfg_data;
				bcse_pkg::REG_SEP_START:  start_q     <= cfg_data[9:0];
				bcse_pkg::REG_SEP_CUTOFF: cutoff_q    <= cfg_data[9:0];
				bcse_pkg::REG_DOUBLE:     dcs_q       <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			count_q   <= '0;
			k_q       <= '0;
			self_q    <= 1'b0;
			sum_q     <= '0;
			ovf_q     <= 1'b0;
			sat_q     <= 1'b0;
			done_q    <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (32'(clr_q) == CLR_N - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && mode == bcse_pkg::MODE_BEAD) begin
						last_q  <= last_bead;
						self_q  <= 1'b1;
						k_q     <= '0;
						state_q <= ST_DIFF;
					end
				end
				ST_FETCH: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					if (sep_d < 16'(start_q) || sep_d > 16'(cutoff_q)) begin
						self_q  <= 1'b0;
						k_q     <= adv_k;
						state_q <= adv_state;
					end else begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					off_q <= sel_off;
					if (rule_q == bcse_pkg::RULE_LOOKUP) begin
						if (32'(s_q) >= 32'(MAX_SEPARATION)) begin
							ovf_q   <= 1'b1;
							self_q  <= 1'b0;
							k_q     <= adv_k;
							state_q <= adv_state;
						end else begin
							state_q <= ST_LOOK;
						end
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_BIN;
					end
				end
				ST_LOOK: begin
					state_q <= ST_BIN;
				end
				ST_BIN: begin
					if (32'(bin_q) >= 32'(NUM_BINS)) begin
						ovf_q   <= 1'b1;
						self_q  <= 1'b0;
						k_q     <= adv_k;
						state_q <= adv_state;
					end else begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (total[bcse_pkg::SUM_W] != total[bcse_pkg::SUM_W-1]) begin
						sum_q <= total[bcse_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
						sat_q <= 1'b1;
					end else begin
						sum_q <= total[bcse_pkg::SUM_W-1:0];
					end
					self_q  <= 1'b0;
					k_q     <= adv_k;
					state_q <= adv_state;
				end
				ST_DONE: begin
					if (st_we) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (last_q) begin
						done_q  <= 1'b1;
						count_q <= '0;
						sum_q   <= '0;
						ovf_q   <= 1'b0;
						sat_q   <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers with no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			bead_q  <= bead_index;
			dense_q <= DNS_W'(small_cnt_q) * DNS_W'(bcse_pkg::nz_size(small_sz_q));
		end
		if (state_q == ST_DIFF) begin
			s_q <= 10'(sep_d - 16'(start_q));
		end
		if (state_q == ST_DIV && div_done) begin
			bin_q <= bcse_pkg::BIN_Q_W'(div_quo) + bcse_pkg::BIN_Q_W'(off_q);
		end else if (state_q == ST_LOOK) begin
			bin_q <= bcse_pkg::BIN_Q_W'(lk_q);
		end
		if (state_q == ST_DONE && last_q) begin
			energy_q  <= sum_q;
			bin_ovf_q <= ovf_q;
			sat_out_q <= sat_q;
		end
	end

	// Memories: one write port each, registered reads.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			if (32'(clr_q) < 32'(MAX_SEPARATION)) begin
				lookup_mem[clr_q[LK_W-1:0]] <= '0;
			end
			if (32'(clr_q) < 32'(NUM_BINS)) begin
				weight_mem[BIN_W'(clr_q)] <= '0;
			end
		end
		if (ld_weight) begin
			weight_mem[BIN_W'(table_address)] <= table_value;
		end
		if (ld_lookup) begin
			lookup_mem[LK_W'(table_address)] <= BIN_W'(table_value);
		end
		if (st_we) begin
			bead_mem[count_q[IDX_W-1:0]] <= bead_q;
		end
		rd_bead_q <= bead_mem[k_q[IDX_W-1:0]];
		w_q       <= weight_mem[bin_q[BIN_W-1:0]];
		lk_q      <= lookup_mem[LK_W'(s_q)];
	end

	assign done         = done_q;
	assign energy       = energy_q;
	assign bin_overflow = bin_ovf_q;
	assign saturated    = sat_out_q;

endmodule

/* design/bcse_checker.sv */
// Port-level checker of the contact separation energy block and its bind.
`include "binned_contact_separation_energy_defines.svh"

module bcse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] mode,
	input logic       done
);

	`BCSE_ASSERT_SAME(a_done_idle, done, !busy, "result word shown while busy")
	`BCSE_ASSERT_NEXT(a_done_single, done, !done, "result word repeated")
	`BCSE_ASSERT_NEXT(a_bead_busy, start && !busy && mode == bcse_pkg::MODE_BEAD, busy, "bead word did not start work")
	`BCSE_ASSERT_NEXT(a_load_quiet, start && !busy && mode != bcse_pkg::MODE_BEAD, !done && !busy, "load word produced activity")

endmodule

bind binned_contact_separation_energy bcse_checker u_bcse_checker (.*);
